/* src/utf8_to_utf16_decoder_unit_macros.svh */
// assertion helpers for the transcoder
`ifndef UTF8_TO_UTF16_DECODER_UNIT_MACROS_SVH
`define UTF8_TO_UTF16_DECODER_UNIT_MACROS_SVH

// plain property, sampled on clk, off while reset is held
`define UTF8DEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// overlapping implication
`define UTF8DEC_ASSERT_IMP(lbl, ante, cons, msg) \
  `UTF8DEC_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define UTF8DEC_ASSERT_NXT(lbl, ante, cons, msg) \
  `UTF8DEC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* src/utf8dec_pkg.sv */
`default_nettype none

package utf8dec_pkg;

  localparam logic [15:0] REPL_UNIT = 16'hFFFD;
  localparam logic [15:0] HI_SURR   = 16'hD800;
  localparam logic [15:0] LO_SURR   = 16'hDC00;
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // lead byte classes
  localparam logic [2:0] LC_ASCII = 3'd0;
  localparam logic [2:0] LC_TWO   = 3'd1;
  localparam logic [2:0] LC_THREE = 3'd2;
  localparam logic [2:0] LC_FOUR  = 3'd3;
  localparam logic [2:0] LC_STRAY = 3'd4;

  // one run of bytes to decode, lead first
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
    logic            last;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_req_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
    logic        string_end;
    logic        fits_latin1;
    logic [15:0] unit_count;
  } result_t;

  function automatic logic [2:0] lead_class(input logic [7:0] b);
    logic [2:0] c;
    if (b[7] == 1'b0)                c = LC_ASCII;
    else if ((b & 8'hE0) == 8'hC0)   c = LC_TWO;
    else if ((b & 8'hF0) == 8'hE0)   c = LC_THREE;
    else if ((b & 8'hF8) == 8'hF0)   c = LC_FOUR;
    else                             c = LC_STRAY;
    return c;
  endfunction

endpackage

`default_nettype wire

/* src/utf8dec_if.sv */
`default_nettype none

interface utf8dec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface utf8dec_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        run_last;
  logic        string_end;
  logic        fits_latin1;
  logic [15:0] unit_count;

  modport source(output valid, output code_unit, output run_last, output string_end,
                 output fits_latin1, output unit_count, input ready);
  modport sink(input valid, input code_unit, input run_last, input string_end,
               input fits_latin1, input unit_count, output ready);
endinterface

`default_nettype wire

/* src/utf8dec_front.sv */
`default_nettype none

module utf8dec_front
  import utf8dec_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  utf8dec_in_if.sink   in_bus,
  input  logic         q_full,
  output job_req_t     push
);

  logic [1:0] need_r, need_nxt;
  logic [1:0] held_r, held_nxt;
  logic [7:0] lead_r, lead_nxt;
  logic [7:0] fol_r   [2];
  logic [7:0] fol_nxt [2];

  logic       accept;
  logic [7:0] b;
  logic       last;
  logic [1:0] need_b;

  assign in_bus.ready = !q_full;
  assign accept       = in_bus.valid && in_bus.ready;
  assign b            = in_bus.data_byte;
  assign last         = in_bus.last_byte;

  always_comb begin
    case (lead_class(b))
      LC_TWO:   need_b = 2'd1;
      LC_THREE: need_b = 2'd2;
      LC_FOUR:  need_b = 2'd3;
      default:  need_b = 2'd0;
    endcase
  end

  always_comb begin
    need_nxt       = need_r;
    held_nxt       = held_r;
    lead_nxt       = lead_r;
    fol_nxt        = fol_r;
    push.valid     = 1'b0;
    // current byte lands at every slot past the buffered ones
    push.job.bytes = {b, b, b, b};
    push.job.len   = 3'd1;
    push.job.last  = last;
    if (accept) begin
      if (need_r == 2'd0) begin
        if (need_b == 2'd0 || last) begin
          push.valid = 1'b1;
        end else begin
          lead_nxt = b;
          need_nxt = need_b;
          held_nxt = 2'd0;
        end
      end else if ((3'({1'b0, held_r}) + 3'd1 >= 3'({1'b0, need_r})) || last) begin
        push.valid        = 1'b1;
        push.job.bytes[0] = lead_r;
        if (held_r != 2'd0) push.job.bytes[1] = fol_r[0];
        if (held_r == 2'd2) push.job.bytes[2] = fol_r[1];
        push.job.len = 3'({1'b0, held_r}) + 3'd2;
        need_nxt     = 2'd0;
        held_nxt     = 2'd0;
      end else begin
        fol_nxt[held_r[0]] = b;
        held_nxt           = held_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r <= 2'd0;
      held_r <= 2'd0;
    end else begin
      need_r <= need_nxt;
      held_r <= held_nxt;
    end
    lead_r <= lead_nxt;
    fol_r  <= fol_nxt;
  end

endmodule

`default_nettype wire

/* src/utf8dec_queue.sv */
`default_nettype none

module utf8dec_queue
  import utf8dec_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  job_req_t push,
  input  logic     pop,
  output logic     q_full,
  output job_req_t head
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              do_push, do_pop;

  assign q_full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.job   = mem_r[rd_ptr_r];
  assign do_push    = push.valid && !q_full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
    if (do_push) mem_r[wr_ptr_r] <= push.job;
  end

endmodule

`default_nettype wire

/* src/utf8dec_back.sv */
`default_nettype none

module utf8dec_back
  import utf8dec_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
)(
  input  logic          clk,
  input  logic          rst_n,
  input  job_req_t      head,
  output logic          pop,
  utf8dec_out_if.source out_bus
);

  logic [1:0]             p_r, p_nxt;
  logic                   half_r, half_nxt;
  logic                   latin_r, latin_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt, cnt_inc;
  logic                   ov_r, ov_nxt;
  result_t                res_r, res_nxt;

  logic        fire;
  logic [7:0]  c, b1, b2, b3;
  logic [2:0]  rem, adv, next_pos;
  logic [10:0] cp2;
  logic [15:0] cp3;
  logic [20:0] cp4, v;
  logic [15:0] unit, shown;
  logic        ok, done, end_now, latin_now;
  logic [31:0] cnt_wide;

  assign fire = head.valid && (!ov_r || out_bus.ready);

  assign c   = head.job.bytes[p_r];
  assign b1  = head.job.bytes[p_r + 2'd1];
  assign b2  = head.job.bytes[p_r + 2'd2];
  assign b3  = head.job.bytes[3];
  assign rem = head.job.len - 3'({1'b0, p_r});

  assign cp2 = {c[4:0], b1[5:0]};
  assign cp3 = {c[3:0], b1[5:0], b2[5:0]};
  // four-byte sequences only decode from slot zero
  assign cp4 = {c[2:0], b1[5:0], b2[5:0], b3[5:0]};
  assign v   = cp4 - SUPP_BASE;

  always_comb begin
    unit = REPL_UNIT;
    adv  = 3'd1;
    ok   = 1'b0;
    case (lead_class(c))
      LC_ASCII: begin
        unit = {8'h00, c};
        ok   = 1'b1;
      end
      LC_TWO: begin
        if (rem >= 3'd2) begin
          unit = {5'b0, cp2};
          adv  = 3'd2;
          ok   = (cp2 <= 11'h0FF);
        end
      end
      LC_THREE: begin
        if (rem >= 3'd3) begin
          unit = cp3;
          adv  = 3'd3;
        end
      end
      LC_FOUR: begin
        if (rem >= 3'd4) begin
          if (cp4 >= SUPP_BASE) begin
            // surrogate pair over two beats, high half kept to 16 bits
            if (!half_r) begin
              unit = HI_SURR + 16'(v[20:10]);
              adv  = 3'd0;
            end else begin
              unit = LO_SURR + {6'b0, v[9:0]};
              adv  = 3'd4;
            end
          end else begin
            unit = cp4[15:0];
            adv  = 3'd4;
          end
        end
      end
      default: begin
        unit = REPL_UNIT;
      end
    endcase
  end

  assign next_pos  = 3'({1'b0, p_r}) + adv;
  assign done      = (adv != 3'd0) && (next_pos >= head.job.len);
  assign end_now   = done && head.job.last;
  assign latin_now = latin_r && ok;
  assign cnt_inc   = (cnt_r == {COUNT_WIDTH{1'b1}}) ? cnt_r : cnt_r + COUNT_WIDTH'(1);
  assign cnt_wide  = 32'(cnt_inc);
  assign shown     = (cnt_wide > 32'h0000_FFFF) ? 16'hFFFF : cnt_wide[15:0];
  assign pop       = fire && done;

  always_comb begin
    p_nxt     = p_r;
    half_nxt  = half_r;
    latin_nxt = latin_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r;
    res_nxt   = res_r;
    if (fire) begin
      ov_nxt              = 1'b1;
      res_nxt.code_unit   = unit;
      res_nxt.run_last    = done;
      res_nxt.string_end  = end_now;
      res_nxt.fits_latin1 = end_now && latin_now;
      res_nxt.unit_count  = end_now ? shown : 16'h0000;
      p_nxt               = done ? 2'd0 : next_pos[1:0];
      half_nxt            = (adv == 3'd0);
      latin_nxt           = end_now ? 1'b1 : latin_now;
      cnt_nxt             = end_now ? '0 : cnt_inc;
    end else if (out_bus.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r     <= 2'd0;
      half_r  <= 1'b0;
      latin_r <= 1'b1;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      p_r     <= p_nxt;
      half_r  <= half_nxt;
      latin_r <= latin_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_bus.valid       = ov_r;
  assign out_bus.code_unit   = res_r.code_unit;
  assign out_bus.run_last    = res_r.run_last;
  assign out_bus.string_end  = res_r.string_end;
  assign out_bus.fits_latin1 = res_r.fits_latin1;
  assign out_bus.unit_count  = res_r.unit_count;

endmodule

`default_nettype wire

/* src/utf8_to_utf16_decoder_unit.sv */
// channel | dir | payload                                                   | handshake
// in_bus  | in  | data_byte[7:0], last_byte                                 | valid/ready
// out_bus | out | code_unit[15:0], run_last, string_end, fits_latin1,       | valid/ready
//         |     | unit_count[15:0]                                          |
//
// one byte taken per cycle while the four-entry job queue has room
// decoder emits one code unit per cycle while out_bus is not stalled; a byte run yields 1 to 3 units
// (surrogate pair: 2, string ending inside a sequence: up to 3)
// a run's first result passes through the job queue and then the output register
// reset: synchronous, active low, clears the queue, sequence and string state
// an out stall holds the output register, then the decoder, then the queue
`default_nettype none

`include "utf8_to_utf16_decoder_unit_macros.svh"

module utf8_to_utf16_decoder_unit
  import utf8dec_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
)(
  input  logic          clk,
  input  logic          rst_n,
  utf8dec_in_if.sink    in_bus,
  utf8dec_out_if.source out_bus
);

  job_req_t push;
  job_req_t head;
  logic     q_full;
  logic     pop;

  utf8dec_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .q_full (q_full),
    .push   (push)
  );

  utf8dec_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .pop    (pop),
    .q_full (q_full),
    .head   (head)
  );

  utf8dec_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .pop     (pop),
    .out_bus (out_bus)
  );

  `UTF8DEC_ASSERT_NXT(a_push_fills, push.valid && !q_full && !pop, head.valid, "queue lost a job")
  `UTF8DEC_ASSERT_IMP(a_end_count, out_bus.valid && out_bus.string_end, out_bus.unit_count != 16'd0, "string end with zero count")
  `UTF8DEC_ASSERT_IMP(a_mid_quiet, out_bus.valid && !out_bus.string_end, out_bus.unit_count == 16'd0 && !out_bus.fits_latin1, "status set before string end")

endmodule

`default_nettype wire

/* verif/utf8_to_utf16_decoder_unit_test.sv */
`timescale 1ns / 1ps

module utf8_to_utf16_decoder_unit_test;
  import utf8dec_pkg::*;

  localparam int COUNT_WIDTH = 16;
  localparam int RANDOM_BYTES = 250;
  localparam int TAIL_BYTES = 40;

  typedef enum logic [2:0] {
    BK_ASCII,
    BK_TWO,
    BK_THREE,
    BK_FOUR,
    BK_STRAY
  } byte_kind_e;

  // directed stimulus; typed rows are single-unit strings with a count of one
  typedef struct packed {
    logic [7:0]  data;
    logic        fin;
    logic        typed;
    logic [15:0] unit;
    logic        fits;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 26;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, 16'h0000, 1'b1},
    '{8'h7F, 1'b1, 1'b1, 16'h007F, 1'b1},
    '{8'h80, 1'b1, 1'b1, REPL_UNIT, 1'b0},
    '{8'hF8, 1'b1, 1'b1, REPL_UNIT, 1'b0},
    '{8'hFF, 1'b1, 1'b1, REPL_UNIT, 1'b0},
    '{8'hC2, 1'b1, 1'b1, REPL_UNIT, 1'b0},
    '{8'hC3, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hA9, 1'b1, 1'b0, 16'h0000, 1'b0},
    '{8'hE2, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h82, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hAC, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hF0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h9F, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h98, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hF0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h80, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hF7, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hBF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hF0, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'h41, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{8'hC3, 1'b1, 1'b0, 16'h0000, 1'b0}
  };

  logic clk;
  logic rst_n;

  utf8dec_in_if  in_bus();
  utf8dec_out_if out_bus();

  utf8_to_utf16_decoder_unit #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_bus(in_bus),
    .out_bus(out_bus)
  );

  // predictor state
  logic [7:0]             lead_q;
  logic [7:0]             follow_q [2];
  logic [1:0]             need_q;
  logic [1:0]             held_q;
  logic                   latin1_q;
  logic [COUNT_WIDTH-1:0] count_q;

  logic [15:0] run_units [$];
  result_t     fresh_results [$];
  result_t     expected_units [$];

  int  errors;
  bit  idle_on;
  int  stall_left;

  function automatic byte_kind_e kind_of(input logic [7:0] b);
    byte_kind_e k;
    if (b[7] == 1'b0) k = BK_ASCII;
    else if (b[7:5] == 3'b110) k = BK_TWO;
    else if (b[7:4] == 4'b1110) k = BK_THREE;
    else if (b[7:3] == 5'b11110) k = BK_FOUR;
    else k = BK_STRAY;
    return k;
  endfunction

  function automatic void emit_unit(input logic [15:0] u);
    run_units.push_back(u);
    if (count_q != '1) count_q = count_q + 1'b1;
  endfunction

  // decode a buffered run starting at a lead byte
  function automatic void decode_run(input logic [3:0][7:0] run, input int len);
    int          p;
    int          rem;
    logic [20:0] cp;
    logic [20:0] v;
    p = 0;
    while (p < len) begin
      rem = len - p;
      case (kind_of(run[p]))
        BK_ASCII: begin
          emit_unit({8'h00, run[p]});
          p += 1;
        end
        BK_TWO: begin
          if (rem >= 2) begin
            cp = {10'd0, run[p][4:0], run[p+1][5:0]};
            if (cp > 21'h0000FF) latin1_q = 1'b0;
            emit_unit(cp[15:0]);
            p += 2;
          end else begin
            latin1_q = 1'b0;
            emit_unit(REPL_UNIT);
            p += 1;
          end
        end
        BK_THREE: begin
          latin1_q = 1'b0;
          if (rem >= 3) begin
            emit_unit({run[p][3:0], run[p+1][5:0], run[p+2][5:0]});
            p += 3;
          end else begin
            emit_unit(REPL_UNIT);
            p += 1;
          end
        end
        BK_FOUR: begin
          latin1_q = 1'b0;
          if (rem >= 4) begin
            cp = {run[p][2:0], run[p+1][5:0], run[p+2][5:0], run[p+3][5:0]};
            if (cp >= SUPP_BASE) begin
              v = cp - SUPP_BASE;
              // high half can run past the surrogate range, kept at 16 bits
              emit_unit(HI_SURR + {5'd0, v[20:10]});
              emit_unit(LO_SURR + {6'd0, v[9:0]});
            end else begin
              emit_unit(cp[15:0]);
            end
            p += 4;
          end else begin
            emit_unit(REPL_UNIT);
            p += 1;
          end
        end
        default: begin
          latin1_q = 1'b0;
          emit_unit(REPL_UNIT);
          p += 1;
        end
      endcase
    end
  endfunction

  // advance the predictor by one accepted byte, results go to fresh_results
  function automatic void predict_byte(input logic [7:0] b, input logic fin);
    logic [3:0][7:0] run;
    int              len;
    int              need;
    result_t         r;
    run = '0;
    run_units.delete();
    fresh_results.delete();
    if (need_q == 2'd0) begin
      case (kind_of(b))
        BK_TWO:   need = 1;
        BK_THREE: need = 2;
        BK_FOUR:  need = 3;
        default:  need = 0;
      endcase
      if (need == 0 || fin) begin
        run[0] = b;
        decode_run(run, 1);
      end else begin
        lead_q = b;
        need_q = need[1:0];
        held_q = 2'd0;
      end
    end else begin
      if (int'(held_q) + 1 >= int'(need_q) || fin) begin
        run[0] = lead_q;
        len = 1;
        for (int k = 0; k < int'(held_q); k++) begin
          run[len] = follow_q[k];
          len++;
        end
        run[len] = b;
        len++;
        decode_run(run, len);
        need_q = 2'd0;
        held_q = 2'd0;
      end else begin
        follow_q[held_q[0]] = b;
        held_q = held_q + 2'd1;
      end
    end
    for (int k = 0; k < run_units.size() && k < 3; k++) begin
      r.code_unit   = run_units[k];
      r.run_last    = (k == run_units.size() - 1);
      r.string_end  = r.run_last && fin;
      r.fits_latin1 = r.string_end ? latin1_q : 1'b0;
      if (!r.string_end) r.unit_count = 16'd0;
      else if (count_q > 16'hFFFF) r.unit_count = 16'hFFFF;
      else r.unit_count = count_q[15:0];
      fresh_results.push_back(r);
    end
    if (fin) begin
      latin1_q = 1'b1;
      count_q  = '0;
    end
  endfunction

  // entered and left at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic fin, input logic typed,
                           input result_t typed_res);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.last_byte <= fin;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predict_byte(b, fin);
    if (typed) begin
      expected_units.push_back(typed_res);
    end else begin
      foreach (fresh_results[k]) expected_units.push_back(fresh_results[k]);
    end
    @(negedge clk);
  endtask

  function automatic logic [7:0] cont_byte();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  task automatic report_failure(input string what, input result_t want, input result_t got);
    errors++;
    if (errors <= 10) begin
      $display("%s: expected unit=%h run_last=%b end=%b latin1=%b count=%0d", what,
               want.code_unit, want.run_last, want.string_end, want.fits_latin1,
               want.unit_count);
      $display("    actual   unit=%h run_last=%b end=%b latin1=%b count=%0d",
               got.code_unit, got.run_last, got.string_end, got.fits_latin1,
               got.unit_count);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // result side stalls in bursts
  initial begin
    out_bus.ready = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.code_unit   = out_bus.code_unit;
      got.run_last    = out_bus.run_last;
      got.string_end  = out_bus.string_end;
      got.fits_latin1 = out_bus.fits_latin1;
      got.unit_count  = out_bus.unit_count;
      if (expected_units.size() == 0) begin
        report_failure("unexpected beat", '0, got);
      end else begin
        want = expected_units.pop_front();
        if (want !== got) report_failure("mismatch", want, got);
      end
    end
  end

  initial begin
    logic [7:0] bytes_q [$];
    int         sent;
    int         chars;
    int         conts;
    result_t    typed_res;
    errors           = 0;
    idle_on          = 1'b1;
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = 8'h00;
    in_bus.last_byte = 1'b0;
    lead_q           = 8'h00;
    follow_q[0]      = 8'h00;
    follow_q[1]      = 8'h00;
    need_q           = 2'd0;
    held_q           = 2'd0;
    latin1_q         = 1'b1;
    count_q          = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      typed_res = '{code_unit: directed_rows[i].unit, run_last: 1'b1, string_end: 1'b1,
                    fits_latin1: directed_rows[i].fits, unit_count: 16'd1};
      push_byte(directed_rows[i].data, directed_rows[i].fin, directed_rows[i].typed,
                typed_res);
    end

    // random strings: mostly well-formed characters, some stray and cut-off ones
    sent = 0;
    while (sent < RANDOM_BYTES) begin
      // no idling over the last strings
      idle_on = (sent < RANDOM_BYTES - TAIL_BYTES) && ($urandom_range(0, 2) != 0);
      bytes_q.delete();
      chars = $urandom_range(1, 10);
      repeat (chars) begin
        case ($urandom_range(0, 9))
          0, 1, 2: bytes_q.push_back(8'($urandom_range(0, 127)));
          3, 4: begin
            if ($urandom_range(0, 1) == 0) bytes_q.push_back(8'($urandom_range(8'hC2, 8'hC3)));
            else bytes_q.push_back({3'b110, 5'($urandom_range(0, 31))});
            bytes_q.push_back(cont_byte());
          end
          5: begin
            bytes_q.push_back({4'b1110, 4'($urandom_range(0, 15))});
            repeat (2) bytes_q.push_back(cont_byte());
          end
          6: begin
            bytes_q.push_back({5'b11110, 3'($urandom_range(0, 7))});
            repeat (3) bytes_q.push_back(cont_byte());
          end
          7: begin
            if ($urandom_range(0, 1) == 0) bytes_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
            else bytes_q.push_back(8'($urandom_range(8'hF8, 8'hFF)));
          end
          8: begin
            // lead with too few continuation bytes
            conts = $urandom_range(1, 3);
            case (conts)
              1: bytes_q.push_back({3'b110, 5'($urandom_range(0, 31))});
              2: bytes_q.push_back({4'b1110, 4'($urandom_range(0, 15))});
              default: bytes_q.push_back({5'b11110, 3'($urandom_range(0, 7))});
            endcase
            repeat ($urandom_range(0, conts - 1)) bytes_q.push_back(cont_byte());
          end
          default: bytes_q.push_back(8'($urandom_range(0, 255)));
        endcase
      end
      foreach (bytes_q[i]) begin
        push_byte(bytes_q[i], i == bytes_q.size() - 1, 1'b0, '0);
      end
      sent += bytes_q.size();
    end
    in_bus.valid <= 1'b0;

    while (expected_units.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* utf8_to_utf16_decoder_unit.f */
+incdir+src
src/utf8dec_pkg.sv
src/utf8dec_if.sv
src/utf8dec_front.sv
src/utf8dec_queue.sv
src/utf8dec_back.sv
src/utf8_to_utf16_decoder_unit.sv
verif/utf8_to_utf16_decoder_unit_test.sv
